>>> hdl/i2c_master_byte_engine_core_defines.svh
// assertion macros shared by the i2c master byte engine checkers
// no dependencies; included by the checker file
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, muted while reset is asserted
`define I2CM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, muted while reset is asserted
`define I2CM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/i2cm_pkg.sv
// shared types and constants of the i2c master byte engine
// no dependencies; used by every module of the block
package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int TPUS_W        = 10;
    localparam int LIMIT_W       = 8;
    localparam int CFG_DATA_W    = 10;
    localparam int DLY_W         = 14;
    localparam int BIT_W         = 4;

    // reset values of the configuration registers
    localparam logic [TPUS_W-1:0]  TPUS_RESET  = TPUS_W'(1);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(250);

    // configuration register indexes
    localparam logic CFG_IDX_TPUS  = 1'b0;
    localparam logic CFG_IDX_LIMIT = 1'b1;

    // command codes
    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd4;
    localparam logic [2:0] CMD_READ     = 3'd5;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_byte;
        logic       master_nack;
        logic       sda_level;
    } t_in_beat;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive_level;
        logic       sda_output_enable;
        logic       busy_res;
        logic       command_done;
        logic [7:0] received_byte;
        logic       ack_status;
    } t_out_beat;

    typedef struct packed {
        logic [TPUS_W-1:0]  tpus;
        logic [LIMIT_W-1:0] ack_limit;
    } t_cfg;

endpackage

>>> hdl/i2cm_seq.sv
// bus step sequencer: holds the line and counter state, advances one tick per beat
// depends on i2cm_pkg
module i2cm_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cm_pkg::t_in_beat i_beat,
    input  i2cm_pkg::t_cfg     i_cfg,
    output i2cm_pkg::t_out_beat o_beat
);
    import i2cm_pkg::*;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_START   = 4'd1;
    localparam logic [3:0] PH_STOP    = 4'd2;
    localparam logic [3:0] PH_WR_PRE  = 4'd3;
    localparam logic [3:0] PH_WR_SET  = 4'd4;
    localparam logic [3:0] PH_WR_HIGH = 4'd5;
    localparam logic [3:0] PH_WR_LOW  = 4'd6;
    localparam logic [3:0] PH_AK_PRE  = 4'd7;
    localparam logic [3:0] PH_AK_HIGH = 4'd8;
    localparam logic [3:0] PH_AK_POLL = 4'd9;
    localparam logic [3:0] PH_AK_HOLD = 4'd10;
    localparam logic [3:0] PH_RD_LOW  = 4'd11;
    localparam logic [3:0] PH_RD_HIGH = 4'd12;
    localparam logic [3:0] PH_MA_SET  = 4'd13;
    localparam logic [3:0] PH_MA_HIGH = 4'd14;

    logic [3:0]         r_phase,  n_phase;
    logic [2:0]         r_active, n_active;
    logic [BIT_W-1:0]   r_bit,    n_bit;
    logic [7:0]         r_shift,  n_shift;
    logic [DLY_W-1:0]   r_delay,  n_delay;
    logic [LIMIT_W-1:0] r_tmo,    n_tmo;
    logic               r_scl,    n_scl;
    logic               r_sda,    n_sda;
    logic               r_dir,    n_dir;
    logic               r_ack,    n_ack;

    logic [TPUS_W-1:0] t_eff;
    logic [DLY_W-1:0]  dly2, dly4, dly5;
    logic              enter_en;
    logic [3:0]        enter_ph;
    logic              done;

    // hold times for 2, 4 and 5 microseconds
    assign t_eff = (i_cfg.tpus == '0) ? TPUS_W'(1) : i_cfg.tpus;
    assign dly2  = DLY_W'({t_eff, 1'b0});
    assign dly4  = DLY_W'({t_eff, 2'b00});
    assign dly5  = DLY_W'({t_eff, 2'b00}) + DLY_W'(t_eff);

    // next state for one tick
    always_comb begin
        n_phase  = r_phase;
        n_active = r_active;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_delay  = r_delay;
        n_tmo    = r_tmo;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_dir    = r_dir;
        n_ack    = r_ack;
        enter_en = 1'b0;
        enter_ph = r_phase;
        done     = 1'b0;

        if (i_step) begin
            // enter a command, the ack poll outcome or the next step, or count down the hold
            if (r_phase == PH_IDLE) begin
                if (i_beat.command >= CMD_START && i_beat.command <= CMD_READ) begin
                    n_active = i_beat.command;
                    n_bit    = '0;
                    enter_en = 1'b1;
                    unique case (i_beat.command)
                        CMD_START: enter_ph = PH_START;
                        CMD_STOP:  enter_ph = PH_STOP;
                        CMD_WRITE: begin
                            n_shift  = i_beat.write_byte;
                            enter_ph = PH_WR_PRE;
                        end
                        CMD_WAIT_ACK: begin
                            n_ack    = 1'b0;
                            enter_ph = PH_AK_PRE;
                        end
                        default: begin
                            n_shift  = '0;
                            n_ack    = i_beat.master_nack;
                            enter_ph = PH_RD_LOW;
                        end
                    endcase
                end
            end else if (r_phase == PH_AK_POLL) begin
                if (!i_beat.sda_level) begin
                    enter_en = 1'b1;
                    enter_ph = PH_AK_HOLD;
                end else if (r_tmo >= i_cfg.ack_limit) begin
                    // timeout: release the bus with a stop, report nack
                    n_ack    = 1'b1;
                    n_bit    = '0;
                    enter_en = 1'b1;
                    enter_ph = PH_STOP;
                end else begin
                    n_tmo = r_tmo + LIMIT_W'(1);
                end
            end else if (r_delay > DLY_W'(1)) begin
                n_delay = r_delay - DLY_W'(1);
            end else begin
                unique case (r_phase)
                    PH_START, PH_STOP: begin
                        if (r_bit < BIT_W'(2)) begin
                            n_bit    = r_bit + BIT_W'(1);
                            enter_en = 1'b1;
                            enter_ph = r_phase;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    PH_WR_PRE:  begin enter_en = 1'b1; enter_ph = PH_WR_SET;  end
                    PH_WR_SET:  begin enter_en = 1'b1; enter_ph = PH_WR_HIGH; end
                    PH_WR_HIGH: begin enter_en = 1'b1; enter_ph = PH_WR_LOW;  end
                    PH_WR_LOW: begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit   = r_bit + BIT_W'(1);
                        if (n_bit >= BIT_W'(BITS_PER_BYTE)) begin
                            done = 1'b1;
                        end else begin
                            enter_en = 1'b1;
                            enter_ph = PH_WR_SET;
                        end
                    end
                    PH_AK_PRE:  begin enter_en = 1'b1; enter_ph = PH_AK_HIGH; end
                    PH_AK_HIGH: begin enter_en = 1'b1; enter_ph = PH_AK_POLL; end
                    PH_AK_HOLD: begin
                        n_scl = 1'b0;
                        done  = 1'b1;
                    end
                    PH_RD_LOW:  begin enter_en = 1'b1; enter_ph = PH_RD_HIGH; end
                    PH_RD_HIGH: begin
                        n_bit    = r_bit + BIT_W'(1);
                        enter_en = 1'b1;
                        enter_ph = (n_bit >= BIT_W'(BITS_PER_BYTE)) ? PH_MA_SET : PH_RD_LOW;
                    end
                    PH_MA_SET:  begin enter_en = 1'b1; enter_ph = PH_MA_HIGH; end
                    PH_MA_HIGH: begin
                        n_scl = 1'b0;
                        done  = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_delay = '0;
                    end
                endcase
            end

            // line actions and hold time of the entered step
            if (enter_en) begin
                n_phase = enter_ph;
                unique case (enter_ph)
                    PH_START: begin
                        if (n_bit == BIT_W'(0)) begin
                            n_dir = 1'b1;
                            n_scl = 1'b1;
                            n_sda = 1'b1;
                        end else if (n_bit == BIT_W'(1)) begin
                            n_sda = 1'b0;
                        end else begin
                            n_scl = 1'b0;
                        end
                        n_delay = dly5;
                    end
                    PH_STOP: begin
                        if (n_bit == BIT_W'(0)) begin
                            n_dir = 1'b1;
                            n_scl = 1'b0;
                            n_sda = 1'b0;
                        end else if (n_bit == BIT_W'(1)) begin
                            n_scl = 1'b1;
                        end else begin
                            n_sda = 1'b1;
                        end
                        n_delay = dly5;
                    end
                    PH_WR_PRE: begin
                        n_dir   = 1'b1;
                        n_scl   = 1'b0;
                        n_delay = dly5;
                    end
                    PH_WR_SET: begin
                        n_sda   = n_shift[7];
                        n_delay = dly2;
                    end
                    PH_WR_HIGH: begin
                        n_scl   = 1'b1;
                        n_delay = dly5;
                    end
                    PH_WR_LOW: begin
                        n_scl   = 1'b0;
                        n_delay = dly2;
                    end
                    PH_AK_PRE: begin
                        n_dir   = 1'b0;
                        n_scl   = 1'b0;
                        n_tmo   = '0;
                        n_delay = dly5;
                    end
                    PH_AK_HIGH: begin
                        n_scl   = 1'b1;
                        n_delay = dly2;
                    end
                    PH_AK_POLL: n_delay = '0;
                    PH_AK_HOLD: n_delay = dly2;
                    PH_RD_LOW: begin
                        n_dir   = 1'b0;
                        n_scl   = 1'b0;
                        n_delay = dly2;
                    end
                    PH_RD_HIGH: begin
                        n_scl   = 1'b1;
                        n_shift = {n_shift[6:0], i_beat.sda_level};
                        n_delay = dly4;
                    end
                    PH_MA_SET: begin
                        n_scl   = 1'b0;
                        n_dir   = 1'b1;
                        n_sda   = n_ack;
                        n_delay = dly2;
                    end
                    PH_MA_HIGH: begin
                        n_scl   = 1'b1;
                        n_delay = dly2;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_delay = '0;
                    end
                endcase
            end

            if (done) begin
                n_phase = PH_IDLE;
                n_delay = '0;
            end
        end
    end

    // result fields seen after this tick
    always_comb begin
        o_beat.scl_level         = n_scl;
        o_beat.sda_drive_level   = n_dir & n_sda;
        o_beat.sda_output_enable = n_dir;
        o_beat.busy_res          = (n_phase != PH_IDLE);
        o_beat.command_done      = done;
        o_beat.received_byte     = (done && n_active == CMD_READ) ? n_shift : 8'h00;
        o_beat.ack_status        = done && (n_active == CMD_WAIT_ACK) && n_ack;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_active <= CMD_NONE;
            r_bit    <= '0;
            r_shift  <= '0;
            r_delay  <= '0;
            r_tmo    <= '0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_dir    <= 1'b1;
            r_ack    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_active <= n_active;
            r_bit    <= n_bit;
            r_shift  <= n_shift;
            r_delay  <= n_delay;
            r_tmo    <= n_tmo;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_dir    <= n_dir;
            r_ack    <= n_ack;
        end
    end

endmodule

>>> hdl/i2cm_obuf.sv
// result register with a skid slot, so a stalled consumer does not stop intake at once
// depends on i2cm_pkg
module i2cm_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cm_pkg::t_out_beat i_data,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output i2cm_pkg::t_out_beat o_data
);
    import i2cm_pkg::*;

    logic      r_out_v, r_skid_v;
    t_out_beat r_out, r_skid;
    logic      pop;

    assign pop     = r_out_v & i_ready;
    assign o_space = ~r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule

>>> hdl/i2c_master_byte_engine_core.sv
// top level of the i2c master byte engine: config registers, sequencer, result buffer
// depends on i2cm_pkg, i2cm_seq and i2cm_obuf
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_ready     t_in_beat, one tick
//   result    out        o_out_valid / i_out_ready   t_out_beat, one per tick
//   config    in         i_cfg_we, i_cfg_idx         i_cfg_wdata, no read-back
//
// one tick is taken per clock while o_in_ready is high; its result is registered
// the sequencer's state update is a loop closed through its state registers
// a two-entry result buffer keeps intake going on stall until its skid slot fills,
// after which o_in_ready drops until the consumer takes a beat
// synchronous active-low reset; no clearing pass
module i2c_master_byte_engine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  i2cm_pkg::t_in_beat            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output i2cm_pkg::t_out_beat           o_out_data,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import i2cm_pkg::*;

    t_cfg      r_cfg;
    logic      step;
    logic      space;
    t_out_beat seq_beat;

    assign step       = i_in_valid & space;
    assign o_in_ready = space;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tpus      <= TPUS_RESET;
            r_cfg.ack_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_TPUS:  r_cfg.tpus      <= i_cfg_wdata[TPUS_W-1:0];
                CFG_IDX_LIMIT: r_cfg.ack_limit <= i_cfg_wdata[LIMIT_W-1:0];
                default:       r_cfg.ack_limit <= r_cfg.ack_limit;
            endcase
        end
    end

    i2cm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_beat  (i_in_data),
        .i_cfg   (r_cfg),
        .o_beat  (seq_beat)
    );

    i2cm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step),
        .i_data  (seq_beat),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

>>> hdl/i2cm_chk.sv
// port-level checker for the i2c master byte engine, bound to the top level
// depends on i2cm_pkg and i2c_master_byte_engine_core_defines.svh
`include "i2c_master_byte_engine_core_defines.svh"

module i2cm_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input i2cm_pkg::t_out_beat o_out_data
);

    // a stalled result beat holds
    `I2CM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result beat changed while stalled")

    // intake stops only while a result beat is waiting
    `I2CM_ASSERT_NOW(a_ready_drop, i_clk, i_rst_n, !o_in_ready, o_out_valid, "input stalled with no result waiting")

    // a finished command leaves the engine idle
    `I2CM_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_out_valid && o_out_data.command_done, !o_out_data.busy_res, "busy on the done beat")

    // read data and ack status only on a done beat
    `I2CM_ASSERT_NOW(a_result_on_done, i_clk, i_rst_n, o_out_valid && (o_out_data.received_byte != 8'h00 || o_out_data.ack_status), o_out_data.command_done, "result field set without done")

    // drive level reads zero whenever the master releases the data line
    `I2CM_ASSERT_NOW(a_sda_released, i_clk, i_rst_n, o_out_valid && !o_out_data.sda_output_enable, !o_out_data.sda_drive_level, "drive level set while released")

endmodule

bind i2c_master_byte_engine_core i2cm_chk u_i2cm_chk (.*);
